FILE: design/ansi_text_terminal_grid_unit_defines.svh
// assertion macros for the terminal grid unit
`ifndef ANSI_TEXT_TERMINAL_GRID_UNIT_DEFINES_SVH
`define ANSI_TEXT_TERMINAL_GRID_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ATTG_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("terminal grid assertion failed");
`define ATTG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("terminal grid assertion failed");
`else
`define ATTG_ASSERT(lbl, expr)
`define ATTG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: design/attg_pkg.sv
// shared types and constants of the terminal grid unit
package attg_pkg;

   localparam int ROWS_DEFAULT       = 32;
   localparam int COLS_DEFAULT       = 128;
   localparam int MAX_PARAMS_DEFAULT = 8;

   localparam logic [15:0] PARAM_MAX = 16'hffff;

   localparam logic [7:0] CH_ESC   = 8'h1b;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LBRK  = 8'h5b;
   localparam logic [7:0] CH_SEMI  = 8'h3b;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] FINAL_LO = 8'h40;
   localparam logic [7:0] FINAL_HI = 8'h7e;
   localparam logic [7:0] INTER_LO = 8'h20;
   localparam logic [7:0] INTER_HI = 8'h3f;
   localparam logic [7:0] FIN_SGR  = 8'h6d;
   localparam logic [7:0] FIN_UP   = 8'h41;
   localparam logic [7:0] FIN_DOWN = 8'h42;
   localparam logic [7:0] FIN_FWD  = 8'h43;
   localparam logic [7:0] FIN_BACK = 8'h44;
   localparam logic [7:0] FIN_POS  = 8'h48;
   localparam logic [7:0] FIN_POSF = 8'h66;
   localparam logic [7:0] FIN_ED   = 8'h4a;
   localparam logic [7:0] FIN_EL   = 8'h4b;

   localparam logic [3:0] PEN_FG_RESET = 4'd7;
   localparam logic [3:0] PEN_BG_RESET = 4'd0;

   localparam logic [15:0] SGR_BOLD  = 16'd1;
   localparam logic [15:0] FG_LO     = 16'd30;
   localparam logic [15:0] FG_HI     = 16'd37;
   localparam logic [15:0] BG_LO     = 16'd40;
   localparam logic [15:0] BG_HI     = 16'd47;
   localparam logic [15:0] FG_BRT_LO = 16'd90;
   localparam logic [15:0] FG_BRT_HI = 16'd97;
   localparam logic [15:0] BG_BRT_LO = 16'd100;
   localparam logic [15:0] BG_BRT_HI = 16'd107;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_CR, CMD_LF, CMD_BS, CMD_PRINT, CMD_SGR, CMD_UP, CMD_DOWN,
      CMD_RIGHT, CMD_LEFT, CMD_POS, CMD_CLEAR, CMD_EOL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   ch;
      logic [15:0]  p0;
      logic [15:0]  p1;
      logic         home;
   } cmd_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [3:0] fg;
      logic [3:0] bg;
      logic       bold;
      logic       dirty;
   } cell_type;

endpackage

FILE: design/attg_ram.sv
// generic simple dual-port ram with registered read
module attg_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/attg_csi.sv
// escape sequence parser and byte decoder
module attg_csi #(
   parameter int MAX_PARAMS = attg_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            feed,
   input  logic [7:0]                      data_byte,
   input  logic [$clog2(MAX_PARAMS)-1:0]   sgr_idx,
   output attg_pkg::cmd_type               cmd,
   output logic [$clog2(MAX_PARAMS+1)-1:0] count,
   output logic [15:0]                     sgr_val
);
   import attg_pkg::*;

   localparam int PIW = $clog2(MAX_PARAMS);
   localparam int PCW = $clog2(MAX_PARAMS + 1);

   typedef enum logic [1:0] {PH_TEXT, PH_ESC, PH_CSI, PH_SKIP} phase_type;

   phase_type        phase_ff, phase_in;
   logic [15:0]      param_ff [MAX_PARAMS];
   logic [15:0]      param_in [MAX_PARAMS];
   logic [PCW-1:0]   count_ff, count_in;
   logic [PIW-1:0]   wr_idx, rd_idx;
   logic [15:0]      rd_val;
   logic [19:0]      acc;
   logic [PCW-1:0]   cnt1;
   logic             is_final;

   assign wr_idx   = (count_ff == '0) ? '0 : PIW'(count_ff - PCW'(1));
   assign rd_idx   = feed ? wr_idx : sgr_idx;
   assign rd_val   = param_ff[rd_idx];
   assign acc      = (20'(rd_val) << 3) + (20'(rd_val) << 1) + 20'(data_byte - CH_ZERO);
   assign cnt1     = (count_ff == '0) ? PCW'(1) : count_ff;
   assign is_final = (data_byte >= FINAL_LO) && (data_byte <= FINAL_HI);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      param_in = param_ff;
      cmd      = '{kind: CMD_NONE, ch: data_byte, p0: param_ff[0], p1: param_ff[1],
                   home: 1'b0};
      if (feed) begin
         unique case (phase_ff)
            PH_TEXT: begin
               if (data_byte == CH_ESC) begin
                  phase_in = PH_ESC;
               end else if (data_byte == CH_CR) begin
                  cmd.kind = CMD_CR;
               end else if (data_byte == CH_LF) begin
                  cmd.kind = CMD_LF;
               end else if (data_byte == CH_BS) begin
                  cmd.kind = CMD_BS;
               end else if (data_byte >= CH_SPACE) begin
                  cmd.kind = CMD_PRINT;
               end
            end
            PH_ESC: begin
               if (data_byte == CH_LBRK) begin
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                     param_in[i] = '0;
                  end
                  count_in = '0;
                  phase_in = PH_CSI;
               end else begin
                  phase_in = PH_TEXT;
               end
            end
            PH_CSI: begin
               if (data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
                  count_in         = cnt1;
                  param_in[wr_idx] = (acc > 20'(PARAM_MAX)) ? PARAM_MAX : acc[15:0];
               end else if (data_byte == CH_SEMI) begin
                  count_in = (cnt1 < PCW'(MAX_PARAMS)) ? cnt1 + PCW'(1) : cnt1;
               end else if (is_final) begin
                  phase_in = PH_TEXT;
                  unique case (data_byte)
                     FIN_SGR:           cmd.kind = CMD_SGR;
                     FIN_UP:            cmd.kind = CMD_UP;
                     FIN_DOWN:          cmd.kind = CMD_DOWN;
                     FIN_FWD:           cmd.kind = CMD_RIGHT;
                     FIN_BACK:          cmd.kind = CMD_LEFT;
                     FIN_POS, FIN_POSF: cmd.kind = CMD_POS;
                     FIN_ED: begin
                        if (param_ff[0] == 16'd2 || param_ff[0] == 16'd3) begin
                           cmd.kind = CMD_CLEAR;
                           cmd.home = (param_ff[0] == 16'd2);
                        end
                     end
                     FIN_EL: begin
                        if (param_ff[0] == '0) begin
                           cmd.kind = CMD_EOL;
                        end
                     end
                     default: cmd.kind = CMD_NONE;
                  endcase
               end else if (data_byte >= INTER_LO && data_byte <= INTER_HI) begin
                  phase_in = PH_SKIP;
               end else begin
                  phase_in = PH_TEXT;
               end
            end
            PH_SKIP: begin
               if (is_final) begin
                  phase_in = PH_TEXT;
               end
            end
            default: phase_in = PH_TEXT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TEXT;
         count_ff <= '0;
         for (int i = 0; i < MAX_PARAMS; i++) begin
            param_ff[i] <= '0;
         end
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         param_ff <= param_in;
      end
   end

   assign count   = count_ff;
   assign sgr_val = rd_val;

endmodule

FILE: design/ansi_text_terminal_grid_unit.sv
// top level of the terminal grid unit: sequencer around the cell ram
//
// usage
//  req channel: action 0 feeds a terminal byte, action 1 reads one grid cell.
//  rsp channel: one transfer per request with the cursor after the step, the
//  read cell (zero for a byte or an out-of-grid read) and the any_dirty flag.
//  both channels use valid/stall; a transfer happens when valid is high and
//  stall is low.
//  steps: a printed byte reads the cell ram, compares and writes the cell only
//  if it changed; sgr applies its parameters one at a time. a scroll sweeps
//  the cell ram at one entry per cycle, copying (ROWS-1)*2^clog2(COLS) entries
//  and then filling the COLS-wide bottom row; a full clear fills
//  ROWS*2^clog2(COLS) entries, an erase to end of line the rest of the row. the
//  single write port of the cell ram sets these sweeps.
//  reset: synchronous; afterwards the block fills all ROWS*2^clog2(COLS)
//  entries (4096 by default) of the cell ram with blank dirty cells and holds
//  req_stall high until done.
//  stall: the result waits in the output register; a new request is taken
//  meanwhile but its result waits until the previous one has gone out.
`include "ansi_text_terminal_grid_unit_defines.svh"
module ansi_text_terminal_grid_unit #(
   parameter int ROWS       = attg_pkg::ROWS_DEFAULT,
   parameter int COLS       = attg_pkg::COLS_DEFAULT,
   parameter int MAX_PARAMS = attg_pkg::MAX_PARAMS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_read_row,
   input  logic [6:0] req_read_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_cursor_row,
   output logic [7:0] rsp_cursor_col,
   output logic [7:0] rsp_cell_char,
   output logic [3:0] rsp_cell_fg,
   output logic [3:0] rsp_cell_bg,
   output logic       rsp_cell_bold,
   output logic       rsp_cell_dirty,
   output logic       rsp_any_dirty
);
   import attg_pkg::*;

   localparam int RW     = $clog2(ROWS);
   localparam int CW     = $clog2(COLS);
   localparam int CPW    = $clog2(COLS + 1);
   localparam int AW     = RW + CW;
   localparam int DEPTH  = ROWS * (2 ** CW);
   localparam int STRIDE = 2 ** CW;
   localparam int PIW    = $clog2(MAX_PARAMS);
   localparam int PCW    = $clog2(MAX_PARAMS + 1);

   localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [AW-1:0]  COPY_END  = AW'((ROWS - 1) * STRIDE - 1);
   localparam logic [AW-1:0]  BOT_START = AW'((ROWS - 1) * STRIDE);
   localparam logic [AW-1:0]  BOT_END   = AW'((ROWS - 1) * STRIDE + COLS - 1);
   localparam logic [RW-1:0]  ROW_LAST  = RW'(ROWS - 1);
   localparam logic [CPW-1:0] COL_LAST  = CPW'(COLS - 1);
   localparam logic [CPW-1:0] COL_WRAP  = CPW'(COLS);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_STEP, S_EXEC, S_READ_WAIT, S_SGR, S_SCROLL, S_SCR_FLUSH,
      S_FILL, S_PRINT_RD, S_PRINT_CMP, S_DONE
   } state_type;

   state_type      state_ff, state_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CPW-1:0] col_ff, col_in;
   logic [3:0]     pen_fg_ff, pen_fg_in, pen_bg_ff, pen_bg_in;
   logic           pen_bold_ff, pen_bold_in;
   logic           changed_ff, changed_in;
   logic [AW-1:0]  ptr_ff, ptr_in, end_ff, end_in, cwr_ff, cwr_in;
   logic           copy_vld_ff, copy_vld_in;
   logic           print_pend_ff, print_pend_in;
   logic [PIW-1:0] sgr_idx_ff, sgr_idx_in;
   logic           act_ff, act_in;
   logic [7:0]     byte_ff, byte_in;
   logic [4:0]     rrow_ff, rrow_in;
   logic [6:0]     rcol_ff, rcol_in;
   cmd_type        cmd_ff, cmd_in;
   cell_type       res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [4:0]     rsp_row_ff, rsp_row_in;
   logic [7:0]     rsp_col_ff, rsp_col_in;
   cell_type       rsp_cell_ff, rsp_cell_in;

   cmd_type        csi_cmd;
   logic [PCW-1:0] csi_count;
   logic [15:0]    sgr_val;
   logic           feed;

   logic           wr_en, rd_en;
   logic [AW-1:0]  wr_addr, rd_addr;
   cell_type       wr_data, rd_data, blank;
   logic [15:0]    mv_n, pos_r, pos_c;
   logic [16:0]    row_sum, col_sum;
   logic           read_in_grid;
   logic           accept;

   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != S_IDLE);
   assign feed         = (state_ff == S_STEP) && !act_ff;
   assign blank        = '{ch: CH_SPACE, fg: pen_fg_ff, bg: pen_bg_ff, bold: 1'b0,
                           dirty: 1'b1};
   assign mv_n         = (cmd_ff.p0 == '0) ? 16'd1 : cmd_ff.p0;
   assign row_sum      = 17'(row_ff) + 17'(mv_n);
   assign col_sum      = 17'(col_ff) + 17'(mv_n);
   assign pos_r        = (cmd_ff.p0 == '0) ? '0 : cmd_ff.p0 - 16'd1;
   assign pos_c        = (cmd_ff.p1 == '0) ? '0 : cmd_ff.p1 - 16'd1;
   assign read_in_grid = (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLS);

   attg_csi #(.MAX_PARAMS(MAX_PARAMS)) u_csi (
      .clock     (clock),
      .reset     (reset),
      .feed      (feed),
      .data_byte (byte_ff),
      .sgr_idx   (sgr_idx_ff),
      .cmd       (csi_cmd),
      .count     (csi_count),
      .sgr_val   (sgr_val)
   );

   attg_ram #(.WIDTH($bits(cell_type)), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      pen_fg_in     = pen_fg_ff;
      pen_bg_in     = pen_bg_ff;
      pen_bold_in   = pen_bold_ff;
      changed_in    = changed_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      cwr_in        = ptr_ff;
      copy_vld_in   = 1'b0;
      print_pend_in = print_pend_ff;
      sgr_idx_in    = sgr_idx_ff;
      act_in        = act_ff;
      byte_in       = byte_ff;
      rrow_in       = rrow_ff;
      rcol_in       = rcol_ff;
      cmd_in        = cmd_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_cell_in   = rsp_cell_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = blank;
      rd_en         = 1'b0;
      rd_addr       = {RW'(rrow_ff), CW'(rcol_ff)};

      if (copy_vld_ff) begin
         wr_en         = 1'b1;
         wr_addr       = cwr_ff;
         wr_data       = rd_data;
         wr_data.dirty = 1'b1;
      end

      unique case (state_ff)
         S_INIT: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               byte_in  = req_data_byte;
               rrow_in  = req_read_row;
               rcol_in  = req_read_col;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            res_in = '0;
            if (act_ff) begin
               rd_en    = read_in_grid;
               state_in = read_in_grid ? S_READ_WAIT : S_DONE;
            end else begin
               cmd_in   = csi_cmd;
               state_in = S_EXEC;
            end
         end
         S_READ_WAIT: begin
            res_in   = rd_data;
            state_in = S_DONE;
         end
         S_EXEC: begin
            state_in      = S_DONE;
            print_pend_in = 1'b0;
            case (cmd_ff.kind)
               CMD_CR: col_in = '0;
               CMD_LF: begin
                  if (row_ff == ROW_LAST) begin
                     ptr_in   = '0;
                     state_in = S_SCROLL;
                  end else begin
                     row_in = row_ff + RW'(1);
                  end
               end
               CMD_BS: begin
                  if (col_ff != '0) begin
                     col_in = col_ff - CPW'(1);
                  end
               end
               CMD_PRINT: begin
                  state_in = S_PRINT_RD;
                  if (col_ff == COL_WRAP) begin
                     col_in = '0;
                     if (row_ff == ROW_LAST) begin
                        print_pend_in = 1'b1;
                        ptr_in        = '0;
                        state_in      = S_SCROLL;
                     end else begin
                        row_in = row_ff + RW'(1);
                     end
                  end
               end
               CMD_SGR: begin
                  if (csi_count == '0) begin
                     pen_fg_in   = PEN_FG_RESET;
                     pen_bg_in   = PEN_BG_RESET;
                     pen_bold_in = 1'b0;
                  end else begin
                     sgr_idx_in = '0;
                     state_in   = S_SGR;
                  end
               end
               CMD_UP: begin
                  row_in = (mv_n >= 16'(row_ff)) ? '0 : RW'(16'(row_ff) - mv_n);
               end
               CMD_DOWN: begin
                  row_in = (row_sum >= 17'(ROWS)) ? ROW_LAST : RW'(row_sum);
               end
               CMD_RIGHT: begin
                  col_in = (col_sum >= 17'(COLS)) ? COL_LAST : CPW'(col_sum);
               end
               CMD_LEFT: begin
                  col_in = (mv_n >= 16'(col_ff)) ? '0 : CPW'(16'(col_ff) - mv_n);
               end
               CMD_POS: begin
                  row_in = (pos_r >= 16'(ROWS)) ? ROW_LAST : RW'(pos_r);
                  col_in = (pos_c >= 16'(COLS)) ? COL_LAST : CPW'(pos_c);
               end
               CMD_CLEAR: begin
                  changed_in = 1'b1;
                  ptr_in     = '0;
                  end_in     = LAST_ADDR;
                  state_in   = S_FILL;
               end
               CMD_EOL: begin
                  changed_in = 1'b1;
                  if (col_ff < COL_WRAP) begin
                     ptr_in   = {row_ff, col_ff[CW-1:0]};
                     end_in   = {row_ff, CW'(COLS - 1)};
                     state_in = S_FILL;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SGR: begin
            if (sgr_val == '0) begin
               pen_fg_in   = PEN_FG_RESET;
               pen_bg_in   = PEN_BG_RESET;
               pen_bold_in = 1'b0;
            end else if (sgr_val == SGR_BOLD) begin
               pen_bold_in = 1'b1;
            end else if (sgr_val >= FG_LO && sgr_val <= FG_HI) begin
               pen_fg_in = 4'(sgr_val - FG_LO);
            end else if (sgr_val >= BG_LO && sgr_val <= BG_HI) begin
               pen_bg_in = 4'(sgr_val - BG_LO);
            end else if (sgr_val >= FG_BRT_LO && sgr_val <= FG_BRT_HI) begin
               pen_fg_in = 4'(sgr_val - FG_BRT_LO + 16'd8);
            end else if (sgr_val >= BG_BRT_LO && sgr_val <= BG_BRT_HI) begin
               pen_bg_in = 4'(sgr_val - BG_BRT_LO + 16'd8);
            end
            sgr_idx_in = sgr_idx_ff + PIW'(1);
            if (PCW'(sgr_idx_ff) + PCW'(1) == csi_count) begin
               state_in = S_DONE;
            end
         end
         S_SCROLL: begin
            rd_en       = 1'b1;
            rd_addr     = ptr_ff + AW'(STRIDE);
            copy_vld_in = 1'b1;
            cwr_in      = ptr_ff;
            ptr_in      = ptr_ff + AW'(1);
            if (ptr_ff == COPY_END) begin
               state_in = S_SCR_FLUSH;
            end
         end
         S_SCR_FLUSH: begin
            changed_in = 1'b1;
            ptr_in     = BOT_START;
            end_in     = BOT_END;
            state_in   = S_FILL;
         end
         S_FILL: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + AW'(1);
            if (ptr_ff == end_ff) begin
               if (cmd_ff.kind == CMD_CLEAR && cmd_ff.home) begin
                  row_in = '0;
                  col_in = '0;
               end
               state_in = print_pend_ff ? S_PRINT_RD : S_DONE;
            end
         end
         S_PRINT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = {row_ff, col_ff[CW-1:0]};
            state_in = S_PRINT_CMP;
         end
         S_PRINT_CMP: begin
            if (rd_data.ch != byte_ff || rd_data.fg != pen_fg_ff ||
                rd_data.bg != pen_bg_ff || rd_data.bold != pen_bold_ff) begin
               wr_en      = 1'b1;
               wr_addr    = {row_ff, col_ff[CW-1:0]};
               wr_data    = '{ch: byte_ff, fg: pen_fg_ff, bg: pen_bg_ff,
                              bold: pen_bold_ff, dirty: 1'b1};
               changed_in = 1'b1;
            end
            col_in   = col_ff + CPW'(1);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = 5'(row_ff);
               rsp_col_in   = 8'(col_ff);
               rsp_cell_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         row_ff        <= '0;
         col_ff        <= '0;
         pen_fg_ff     <= PEN_FG_RESET;
         pen_bg_ff     <= PEN_BG_RESET;
         pen_bold_ff   <= 1'b0;
         changed_ff    <= 1'b1;
         ptr_ff        <= '0;
         copy_vld_ff   <= 1'b0;
         print_pend_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         pen_fg_ff     <= pen_fg_in;
         pen_bg_ff     <= pen_bg_in;
         pen_bold_ff   <= pen_bold_in;
         changed_ff    <= changed_in;
         ptr_ff        <= ptr_in;
         copy_vld_ff   <= copy_vld_in;
         print_pend_ff <= print_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      end_ff     <= end_in;
      cwr_ff     <= cwr_in;
      sgr_idx_ff <= sgr_idx_in;
      act_ff     <= act_in;
      byte_ff    <= byte_in;
      rrow_ff    <= rrow_in;
      rcol_ff    <= rcol_in;
      cmd_ff     <= cmd_in;
      res_ff     <= res_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cell_char  = rsp_cell_ff.ch;
   assign rsp_cell_fg    = rsp_cell_ff.fg;
   assign rsp_cell_bg    = rsp_cell_ff.bg;
   assign rsp_cell_bold  = rsp_cell_ff.bold;
   assign rsp_cell_dirty = rsp_cell_ff.dirty;
   assign rsp_any_dirty  = changed_ff;

   `ATTG_ASSERT(a_col_range, col_ff <= COL_WRAP)
   `ATTG_ASSERT(a_row_range, 32'(row_ff) < ROWS)
   `ATTG_ASSERT_NEXT(a_rsp_hold, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_row_ff))
   `ATTG_ASSERT_NEXT(a_copy_only_scroll, copy_vld_in, state_ff == S_SCROLL || state_ff == S_SCR_FLUSH)

endmodule
